// ----- rtl/ncp_pkg.sv -----
// ----------------------------------------------------------------------------
// ncp_pkg
// Shared types and constants for the notify command parser and pin table.
// ----------------------------------------------------------------------------
`default_nettype none

package ncp_pkg;

  // Width of a table address carried through the queue (covers 1024 pins)
  localparam int unsigned PIN_IDX_W = 10;

  // Characters of the '#N<index>,<value>#' frame
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Item opcodes
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_FIRST_PIN = 2'd0;
  localparam logic [1:0] CFG_PIN_COUNT = 2'd1;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  rx_char;
    logic [15:0] read_pin;
  } ncp_in_t;

  typedef struct packed {
    logic [15:0] read_value;
    logic        read_ok;
    logic        stored;
    logic [5:0]  stored_index;
    logic [15:0] stored_value;
    logic        frame_error;
  } ncp_out_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } ncp_cfg_t;

  // Classified request handed from the parser to the table side
  typedef struct packed {
    logic                 read_ok;
    logic                 stored;
    logic                 frame_error;
    logic [PIN_IDX_W-1:0] addr;
    logic [15:0]          value;
  } ncp_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/ncp_chan_if.sv -----
// ----------------------------------------------------------------------------
// ncp_chan_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
`default_nettype none

interface ncp_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/notify_command_parser_pin_table.sv -----
// ----------------------------------------------------------------------------
// notify_command_parser_pin_table
// Parses '#N<index>,<value>#' frames from a character stream into a pin
// value table and answers pin read requests from it.
//
//   channel  dir  payload                                        handshake
//   in_i     in   opcode, rx_char, read_pin                      valid/ready
//   out_o    out  read_value, read_ok, stored, stored_index,     valid/ready
//                 stored_value, frame_error
//   cfg_i    in   index (0 first pin, 1 pin count), data         valid/ready
//
// One request per cycle sustained while in_i.ready is high; each result
// passes through the queue and then the result register (parser into queue,
// table access into result register). After reset the table is zeroed one
// entry a cycle, with in_i.ready low. A two-entry queue lets the parser keep
// taking requests while a result waits on out_o. Config writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module notify_command_parser_pin_table #(
  parameter int unsigned MAX_PINS = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ncp_chan_if.sink   in_i,
  ncp_chan_if.source out_o,
  ncp_chan_if.sink   cfg_i
);
  import ncp_pkg::*;

  logic [15:0] first_pin_q;
  logic [6:0]  pin_count_q;

  logic     space, fifo_space, avail, push, pop, clearing;
  ncp_cmd_t push_data, pop_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_pin_q <= '0;
      pin_count_q <= 7'd64;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        CFG_FIRST_PIN: first_pin_q <= cfg_i.data.data;
        CFG_PIN_COUNT: pin_count_q <= cfg_i.data.data[6:0];
        default: ;
      endcase
    end
  end

  assign space = fifo_space && !clearing;

  ncp_front #(
    .MAX_PINS (MAX_PINS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .space_i     (space),
    .first_pin_i (first_pin_q),
    .pin_count_i (pin_count_q),
    .push_o      (push),
    .push_data_o (push_data)
  );

  ncp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .space_o     (fifo_space),
    .avail_o     (avail),
    .pop_i       (pop),
    .pop_data_o  (pop_data)
  );

  ncp_back #(
    .MAX_PINS (MAX_PINS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .avail_i    (avail),
    .cmd_i      (pop_data),
    .pop_o      (pop),
    .clearing_o (clearing),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

// ----- rtl/ncp_ram.sv -----
// ----------------------------------------------------------------------------
// ncp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ncp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ncp_front.sv -----
// ----------------------------------------------------------------------------
// ncp_front
// Accepts items, runs the frame parser and range checks, emits requests.
// ----------------------------------------------------------------------------
`default_nettype none

module ncp_front #(
  parameter int unsigned MAX_PINS = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  ncp_chan_if.sink                   in_i,
  input  wire logic                  space_i,
  input  wire logic [15:0]           first_pin_i,
  input  wire logic [6:0]            pin_count_i,
  output logic                       push_o,
  output ncp_pkg::ncp_cmd_t          push_data_o
);
  import ncp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_CMD   = 2'd1,
    S_INDEX = 2'd2,
    S_VALUE = 2'd3
  } state_e;

  localparam logic [10:0] MaxCnt = 11'(MAX_PINS);

  state_e      state_q, state_d;
  logic [15:0] idx_q, idx_d;
  logic [15:0] val_q, val_d;

  logic        accept;
  logic [10:0] cnt_eff;
  logic [16:0] diff;
  logic        is_digit;
  logic [3:0]  digit;
  logic [19:0] idx_prod;
  logic [19:0] val_prod;
  ncp_cmd_t    cmd;

  assign in_i.ready = space_i;
  assign accept     = in_i.valid && space_i;

  always_comb begin
    cnt_eff  = ({4'b0, pin_count_i} > MaxCnt) ? MaxCnt : {4'b0, pin_count_i};
    diff     = {1'b0, in_i.data.read_pin} - {1'b0, first_pin_i};
    is_digit = (in_i.data.rx_char >= CH_ZERO) && (in_i.data.rx_char <= CH_NINE);
    digit    = 4'(in_i.data.rx_char - CH_ZERO);
    // x*10 as shifts and adds
    idx_prod = ({4'b0, idx_q} << 3) + ({4'b0, idx_q} << 1) + {16'b0, digit};
    val_prod = ({4'b0, val_q} << 3) + ({4'b0, val_q} << 1) + {16'b0, digit};

    state_d = state_q;
    idx_d   = idx_q;
    val_d   = val_q;
    cmd     = '0;

    if (in_i.data.opcode == OP_READ) begin
      if (!diff[16] && (diff[15:0] < {5'b0, cnt_eff})) begin
        cmd.read_ok = 1'b1;
        cmd.addr    = diff[PIN_IDX_W-1:0];
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_i.data.rx_char == CH_HASH) state_d = S_CMD;
        end
        S_CMD: begin
          if (in_i.data.rx_char == CH_N) begin
            state_d = S_INDEX;
            idx_d   = '0;
            val_d   = '0;
          end else begin
            state_d         = S_IDLE;
            cmd.frame_error = 1'b1;
          end
        end
        S_INDEX: begin
          if (is_digit) begin
            idx_d = (idx_prod[19:16] != 4'b0) ? 16'hFFFF : idx_prod[15:0];
          end else if (in_i.data.rx_char == CH_COMMA) begin
            state_d = S_VALUE;
          end else begin
            state_d         = S_IDLE;
            cmd.frame_error = 1'b1;
          end
        end
        S_VALUE: begin
          if (is_digit) begin
            val_d = val_prod[15:0];
          end else if (in_i.data.rx_char == CH_HASH) begin
            state_d = S_IDLE;
            if (idx_q < {5'b0, cnt_eff}) begin
              cmd.stored = 1'b1;
              cmd.addr   = idx_q[PIN_IDX_W-1:0];
              cmd.value  = val_q;
            end
          end else begin
            state_d         = S_IDLE;
            cmd.frame_error = 1'b1;
          end
        end
        default: state_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      val_q   <= '0;
    end else if (accept) begin
      state_q <= state_d;
      idx_q   <= idx_d;
      val_q   <= val_d;
    end
  end

  assign push_o      = accept;
  assign push_data_o = cmd;

endmodule

`default_nettype wire

// ----- rtl/ncp_fifo.sv -----
// ----------------------------------------------------------------------------
// ncp_fifo
// Two-entry request queue between parser and table side.
// ----------------------------------------------------------------------------
`default_nettype none

module ncp_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire ncp_pkg::ncp_cmd_t push_data_i,
  output logic                   space_o,
  output logic                   avail_o,
  input  wire logic              pop_i,
  output ncp_pkg::ncp_cmd_t      pop_data_o
);
  import ncp_pkg::*;

  ncp_cmd_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign space_o    = (count_q != 2'd2);
  assign avail_o    = (count_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ncp_back.sv -----
// ----------------------------------------------------------------------------
// ncp_back
// Pin table side: clears the table after reset, performs stores and reads,
// and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ncp_back #(
  parameter int unsigned MAX_PINS = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              avail_i,
  input  wire ncp_pkg::ncp_cmd_t cmd_i,
  output logic                   pop_o,
  output logic                   clearing_o,
  ncp_chan_if.source             out_o
);
  import ncp_pkg::*;

  localparam int unsigned AW = (MAX_PINS > 1) ? $clog2(MAX_PINS) : 1;
  localparam logic [AW-1:0] LastAddr = AW'(MAX_PINS - 1);

  logic          clr_q;
  logic [AW-1:0] clr_cnt_q;
  logic          out_valid_q;
  ncp_cmd_t      out_q;

  logic          we, re;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic [15:0]   rdata;

  assign clearing_o = clr_q;
  assign pop_o      = avail_i && !clr_q && (!out_valid_q || out_o.ready);

  always_comb begin
    if (clr_q) begin
      we    = 1'b1;
      waddr = clr_cnt_q;
      wdata = '0;
    end else begin
      we    = pop_o && cmd_i.stored;
      waddr = cmd_i.addr[AW-1:0];
      wdata = cmd_i.value;
    end
    re = pop_o && cmd_i.read_ok;
  end

  ncp_ram #(
    .WIDTH (16),
    .DEPTH (MAX_PINS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (cmd_i.addr[AW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
        if (clr_cnt_q == LastAddr) clr_q <= 1'b0;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) out_q <= cmd_i;
  end

  // read data register only moves on a read pop, so it holds while stalled
  assign out_o.valid             = out_valid_q;
  assign out_o.data.read_value   = out_q.read_ok ? rdata : 16'b0;
  assign out_o.data.read_ok      = out_q.read_ok;
  assign out_o.data.stored       = out_q.stored;
  assign out_o.data.stored_index = out_q.stored ? out_q.addr[5:0] : 6'b0;
  assign out_o.data.stored_value = out_q.value;
  assign out_o.data.frame_error  = out_q.frame_error;

endmodule

`default_nettype wire

// ----- rtl/ncp_checker.sv -----
// ----------------------------------------------------------------------------
// ncp_checker
// Port-level checks on the parser/pin table results.
// ----------------------------------------------------------------------------
`default_nettype none

module ncp_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire ncp_pkg::ncp_out_t out_data_i,
  input wire logic              cfg_ready_i
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // a read never reports parser activity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.read_ok |->
      !out_data_i.stored && !out_data_i.frame_error)
    else $error("read result carries parser flags");

  // miss or character result gives zero read value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.read_ok |-> out_data_i.read_value == 16'b0)
    else $error("read value without valid read");

  // store fields are zero without a store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.stored |->
      out_data_i.stored_index == 6'b0 && out_data_i.stored_value == 16'b0)
    else $error("store fields set without store");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("config write stalled");

endmodule

bind notify_command_parser_pin_table ncp_checker u_ncp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data),
  .cfg_ready_i (cfg_i.ready)
);

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the notify command parser and pin table against a cycle-free model
// of the '#N<index>,<value>#' frame parser and the pin value table. Frames,
// pin reads and line noise are sent under random pacing and long output
// stalls. Each reply is compared with the model's answer in arrival order.
// ----------------------------------------------------------------------------

module tb;
  import ncp_pkg::*;

  localparam int unsigned MAX_PINS   = 64;
  localparam int unsigned CLK_HALF   = 2;
  localparam int unsigned RST_CYCLES = 11;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TIMEOUT_NS = 2_000_000;
  localparam int unsigned PHASE_ITEMS = 300;

  // register slots with no function behind them
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  typedef enum logic [1:0] {PS_IDLE, PS_LETTER, PS_INDEX, PS_VALUE} parse_st_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  ncp_chan_if #(.T(ncp_in_t))  in_if  ();
  ncp_chan_if #(.T(ncp_out_t)) out_if ();
  ncp_chan_if #(.T(ncp_cfg_t)) cfg_if ();

  notify_command_parser_pin_table #(
    .MAX_PINS(MAX_PINS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // model state
  logic [15:0] win_first = '0;
  logic [6:0]  win_count = 7'd64;
  parse_st_e   parse_st  = PS_IDLE;
  logic [15:0] index_acc = '0;
  logic [15:0] value_acc = '0;
  logic [15:0] pin_mem [MAX_PINS];

  ncp_out_t    pin_replies_due [$];
  int unsigned mismatch_cnt = 0;
  int unsigned items_sent = 0;

  logic        pace_on = 1'b1;
  logic        sink_hold = 1'b0;
  int unsigned sink_wait = 0;

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------
  function automatic int unsigned window_size();
    return (win_count > MAX_PINS) ? MAX_PINS : win_count;
  endfunction

  function automatic ncp_out_t next_pin_reply(ncp_in_t req);
    ncp_out_t    r;
    int unsigned acc;
    int unsigned off;
    logic [7:0]  c;
    logic        is_digit;
    r = '0;
    c = req.rx_char;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (req.opcode == OP_READ) begin
      if (req.read_pin >= win_first) begin
        off = int'(req.read_pin) - int'(win_first);
        if (off < window_size()) begin
          r.read_value = pin_mem[off];
          r.read_ok    = 1'b1;
        end
      end
    end else begin
      case (parse_st)
        PS_IDLE: begin
          if (c == CH_HASH) parse_st = PS_LETTER;
        end
        PS_LETTER: begin
          if (c == CH_N) begin
            parse_st  = PS_INDEX;
            index_acc = '0;
            value_acc = '0;
          end else begin
            parse_st      = PS_IDLE;
            r.frame_error = 1'b1;
          end
        end
        PS_INDEX: begin
          if (is_digit) begin
            acc = index_acc * 10 + (c - CH_ZERO);
            index_acc = (acc > 65535) ? 16'hFFFF : acc[15:0];
          end else if (c == CH_COMMA) begin
            parse_st = PS_VALUE;
          end else begin
            parse_st      = PS_IDLE;
            r.frame_error = 1'b1;
          end
        end
        default: begin
          if (is_digit) begin
            acc = value_acc * 10 + (c - CH_ZERO);
            value_acc = acc[15:0];  // wraps
          end else if (c == CH_HASH) begin
            if (index_acc < window_size()) begin
              pin_mem[index_acc] = value_acc;
              r.stored       = 1'b1;
              r.stored_index = index_acc[5:0];
              r.stored_value = value_acc;
            end
            parse_st = PS_IDLE;
          end else begin
            parse_st      = PS_IDLE;
            r.frame_error = 1'b1;
          end
        end
      endcase
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Output side: pacing and checking
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : sink_pacing
    int unsigned draw;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      sink_wait    <= 0;
    end else if (sink_hold) begin
      out_if.ready <= 1'b0;
    end else if (out_if.valid && out_if.ready) begin
      draw = pace_on ? $urandom_range(0, 5) : 0;
      out_if.ready <= (draw == 0);
      sink_wait    <= draw;
    end else if (sink_wait > 0) begin
      sink_wait    <= sink_wait - 1;
      out_if.ready <= (sink_wait == 1);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : reply_check
    ncp_out_t want;
    ncp_out_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (pin_replies_due.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected reply: rd=%h ok=%b st=%b idx=%0d val=%h err=%b",
                   got.read_value, got.read_ok, got.stored, got.stored_index,
                   got.stored_value, got.frame_error);
      end else begin
        want = pin_replies_due.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("reply mismatch: expected rd=%h ok=%b st=%b idx=%0d val=%h err=%b",
                     want.read_value, want.read_ok, want.stored, want.stored_index,
                     want.stored_value, want.frame_error);
            $display("                got      rd=%h ok=%b st=%b idx=%0d val=%h err=%b",
                     got.read_value, got.read_ok, got.stored, got.stored_index,
                     got.stored_value, got.frame_error);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Called at a rising edge; returns at a rising edge.
  task automatic send_item(input ncp_in_t req);
    int unsigned gap;
    in_if.data  <= req;
    in_if.valid <= 1'b1;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    pin_replies_due.push_back(next_pin_reply(req));
    items_sent++;
    gap = pace_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_char(input logic [7:0] c);
    ncp_in_t req;
    req.opcode   = OP_CHAR;
    req.rx_char  = c;
    req.read_pin = 16'($urandom_range(0, 65535));
    send_item(req);
  endtask

  task automatic send_pin_read(input logic [15:0] pin);
    ncp_in_t req;
    req.opcode   = OP_READ;
    req.rx_char  = 8'($urandom_range(0, 255));
    req.read_pin = pin;
    send_item(req);
  endtask

  task automatic send_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++) send_char(s[k]);
  endtask

  task automatic send_digits(input int unsigned n);
    repeat (n) send_char(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // mostly around the window edges, sometimes anywhere
  task automatic send_read_near();
    int          off;
    logic [15:0] pin;
    off = int'($urandom_range(0, window_size() + 3)) - 1;
    pin = win_first + off[15:0];
    if ($urandom_range(0, 3) == 0) pin = 16'($urandom_range(0, 65535));
    send_pin_read(pin);
  endtask

  task automatic maybe_read();
    if ($urandom_range(0, 7) == 0) send_read_near();
  endtask

  // well-formed frame with random content; one in eight is broken somewhere
  task automatic send_frame();
    int unsigned broken;
    int unsigned pick;
    broken = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0;
    send_char(CH_HASH);
    send_char((broken == 1) ? 8'($urandom_range(0, 255)) : CH_N);
    pick = $urandom_range(0, 9);
    if (pick < 7) send_text($sformatf("%0d", $urandom_range(0, window_size() + 2)));
    else if (pick < 9) send_digits($urandom_range(1, 7));  // often saturates
    if (broken == 2) send_char(8'($urandom_range(0, 255)));
    maybe_read();
    send_char(CH_COMMA);
    pick = $urandom_range(0, 9);
    if (pick < 7) send_text($sformatf("%0d", $urandom_range(0, 65535)));
    else if (pick < 9) send_digits($urandom_range(1, 8));  // wraps
    if (broken == 3) send_char(8'($urandom_range(0, 255)));
    maybe_read();
    send_char((broken == 4) ? 8'($urandom_range(0, 255)) : CH_HASH);
  endtask

  task automatic wait_replies_done();
    in_if.valid <= 1'b0;
    while (pin_replies_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    ncp_cfg_t w;
    w.index = idx;
    w.data  = val;
    cfg_if.data  <= w;
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    case (idx)
      CFG_FIRST_PIN: win_first = val;
      CFG_PIN_COUNT: win_count = val[6:0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // upper data bits of the count register are junk half the time
  task automatic set_window(input logic [15:0] first, input logic [6:0] count);
    logic [8:0] junk;
    junk = $urandom_range(0, 1) ? 9'($urandom_range(0, 511)) : 9'd0;
    wait_replies_done();
    write_reg(CFG_FIRST_PIN, first);
    write_reg(CFG_PIN_COUNT, {junk, count});
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_frame_parsing();
    send_text("x#N0,9#");      // noise while idle, then a plain store
    send_text("##");           // '#' where the letter belongs
    send_text("#Nx");          // junk inside the index
    send_text("#N63,99999#");  // top entry, value wraps
    send_pin_read(16'd0);
    send_pin_read(16'd63);
    send_pin_read(16'd64);
  endtask

  task automatic test_register_window();
    wait_replies_done();
    write_reg(CFG_SPARE_A, 16'($urandom_range(0, 65535)));
    write_reg(CFG_SPARE_B, 16'($urandom_range(0, 65535)));
    send_pin_read(16'd63);
    set_window(16'hFFFF, 7'd64);
    send_pin_read(16'hFFFF);
    send_pin_read(16'd0);
    send_pin_read(16'hFFFE);
    send_text("#N0,77#");
    send_pin_read(16'hFFFF);
    set_window(16'd0, 7'd0);
    send_pin_read(16'd0);
    send_text("#N0,5#");
    set_window(16'd0, 7'd127);
    send_text("#N63,7#");
    send_pin_read(16'd63);
    send_pin_read(16'd64);
    send_text("#N64,1#");
    send_text("#N99999999,1#");
  endtask

  task automatic test_backpressure();
    set_window(16'd0, 7'd64);
    pace_on <= 1'b0;
    fork
      begin
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        sink_hold <= 1'b0;
      end
    join_none
    repeat (6) send_frame();
    wait_replies_done();  // sender sits out until everything is back
    pace_on <= 1'b1;
    repeat (6) send_frame();
  endtask

  task automatic test_random_traffic();
    logic [15:0] firsts [7];
    logic [6:0]  counts [7];
    int unsigned p;
    int unsigned start;
    int unsigned chunk;
    int unsigned pick;
    firsts = '{16'd0, 16'd100, 16'hFFFF, 16'd0, 16'd40000, 16'd12, 16'd65500};
    counts = '{7'd64, 7'd10, 7'd127, 7'd0, 7'd64, 7'd1, 7'd100};
    for (p = 0; p < 7; p++) begin
      set_window(firsts[p], counts[p]);
      start = items_sent;
      chunk = 0;
      while (items_sent - start < PHASE_ITEMS) begin
        if (items_sent - chunk >= 50) begin
          chunk = items_sent;
          pace_on <= ($urandom_range(0, 3) != 0);
        end
        pick = $urandom_range(0, 9);
        if (pick < 6) send_frame();
        else if (pick < 9) send_read_near();
        else repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    for (int k = 0; k < MAX_PINS; k++) pin_mem[k] = '0;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_frame_parsing();
    test_register_window();
    test_backpressure();
    test_random_traffic();

    wait_replies_done();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && pin_replies_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout, %0d replies outstanding", pin_replies_due.size());
    $display("FAILURE");
    $finish;
  end

endmodule
